// File: rtl/core/smx_pkg.sv
package smx_pkg;

    localparam int CODE_W   = 21;
    localparam int IP_W     = 17;
    localparam int NIP_W    = 18;
    localparam int WORD_W   = 64;
    localparam int LIMIT_W  = 32;
    localparam int SIZE_W   = 11;
    localparam int STATUS_W = 4;
    localparam int DIGIT_W  = 4;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [1:0] REG_PROGRAM_LENGTH   = 2'd0;
    localparam logic [1:0] REG_MAX_INSTRUCTIONS = 2'd1;
    localparam logic [1:0] REG_MAX_BUFFER_SIZE  = 2'd2;

    localparam logic [LIMIT_W-1:0] MAX_INSTR_RESET = 32'd1000000;
    localparam logic [SIZE_W-1:0]  MAX_BUF_RESET   = 11'd1500;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN     = 4'd0,
        ST_HALT    = 4'd1,
        ST_END     = 4'd2,
        ST_BADOP   = 4'd3,
        ST_BADDATA = 4'd4,
        ST_OVER    = 4'd5,
        ST_UNDER   = 4'd6,
        ST_SLOT    = 4'd7,
        ST_OFFSET  = 4'd8,
        ST_SIZE    = 4'd9,
        ST_LIMIT   = 4'd10,
        ST_MODZERO = 4'd11,
        ST_UNSUP   = 4'd12
    } status_t;

    typedef enum logic [4:0] {
        OP_BAD, OP_NOP, OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_XOR, OP_AND, OP_LT, OP_EQ,
        OP_BR, OP_BRT, OP_BRF, OP_PUSH, OP_POP, OP_LD, OP_ST, OP_NEW, OP_DEL,
        OP_RB, OP_WB, OP_PSTK, OP_PN, OP_HLT
    } op_t;

    typedef enum logic [2:0] {
        NIP_HOLD, NIP_STEP1, NIP_STEP2, NIP_JUMP, NIP_COND
    } nip_sel_t;

    typedef enum logic {
        WA_TOP2, WA_FREE
    } wr_addr_t;

    typedef enum logic [2:0] {
        RES_ALU, RES_MUL, RES_MOD, RES_LOAD, RES_DIGIT
    } res_sel_t;

    typedef enum logic [2:0] {
        CNT_HOLD, CNT_INC, CNT_DEC1, CNT_DEC2, CNT_DEC3
    } cnt_op_t;

    typedef enum logic [1:0] {
        MUL_LL, MUL_LH, MUL_HL
    } mul_sel_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD2, S_RD3, S_RD4, S_EXEC, S_MUL1, S_MUL2,
        S_MUL3, S_MULW, S_MODW, S_LD1, S_LD2, S_ST1, S_CLR, S_COMMIT
    } ctrl_state_t;

    typedef struct packed {
        logic     load_item;
        logic     count_instr;
        logic [1:0] rd_depth;
        logic     cap_x;
        logic     cap_y;
        logic     cap_z;
        logic     finish;
        logic     fin_final;
        status_t  fin_status;
        nip_sel_t nip_sel;
        logic     print;
        logic     stk_wr;
        wr_addr_t wr_addr;
        res_sel_t res_sel;
        cnt_op_t  cnt_op;
        mul_sel_t mul_sel;
        logic     acc_load;
        logic     acc_add;
        logic     mod_start;
        logic     slot_addr_ld;
        logic     slot_rd;
        logic     slot_wr;
        logic     slot_alloc;
        logic     slot_free;
        logic     clr_step;
        logic     commit;
    } smx_cmd_t;

    typedef struct packed {
        op_t  op;
        logic stopped;
        logic at_end;
        logic limit_hit;
        logic under;
        logic stack_full;
        logic digit_ok;
        logic y_zero;
        logic slot_ok;
        logic offset_ok;
        logic size_ok;
        logic free_found;
        logic clr_done;
        logic mod_done;
        logic out_free;
    } smx_stat_t;

    function automatic op_t decode_op(input logic [CODE_W-1:0] cp);
        op_t op;
        unique case (cp)
            21'h1F233: op = OP_NOP;
            21'h02795: op = OP_ADD;
            21'h02796: op = OP_SUB;
            21'h0274C: op = OP_MUL;
            21'h02753: op = OP_MOD;
            21'h0274E: op = OP_XOR;
            21'h1F46B: op = OP_AND;
            21'h1F480: op = OP_LT;
            21'h1F4AF: op = OP_EQ;
            21'h1F680: op = OP_BR;
            21'h1F236: op = OP_BRT;
            21'h1F21A: op = OP_BRF;
            21'h023EC: op = OP_PUSH;
            21'h1F51D: op = OP_POP;
            21'h1F4E4: op = OP_LD;
            21'h1F4E5: op = OP_ST;
            21'h1F195: op = OP_NEW;
            21'h1F193: op = OP_DEL;
            21'h1F4C4: op = OP_RB;
            21'h1F4DD: op = OP_WB;
            21'h1F521: op = OP_PSTK;
            21'h1F522: op = OP_PN;
            21'h1F6D1: op = OP_HLT;
            default:   op = OP_BAD;
        endcase
        return op;
    endfunction

    // Top bit flags a recognised digit, the rest is its value.
    function automatic logic [DIGIT_W:0] decode_digit(input logic [CODE_W-1:0] cp);
        logic [DIGIT_W:0] d;
        unique case (cp)
            21'h1F600: d = {1'b1, 4'd0};
            21'h1F601: d = {1'b1, 4'd1};
            21'h1F602: d = {1'b1, 4'd2};
            21'h1F923: d = {1'b1, 4'd3};
            21'h1F61C: d = {1'b1, 4'd4};
            21'h1F604: d = {1'b1, 4'd5};
            21'h1F605: d = {1'b1, 4'd6};
            21'h1F606: d = {1'b1, 4'd7};
            21'h1F609: d = {1'b1, 4'd8};
            21'h1F60A: d = {1'b1, 4'd9};
            21'h1F60D: d = {1'b1, 4'd10};
            default:   d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] op_need(input op_t op);
        logic [1:0] n;
        unique case (op) inside
            OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_XOR, OP_AND,
            OP_LT, OP_EQ, OP_BRT, OP_BRF, OP_LD:          n = 2'd2;
            OP_BR, OP_POP, OP_NEW, OP_DEL, OP_PN:          n = 2'd1;
            OP_ST:                                         n = 2'd3;
            default:                                       n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

// File: rtl/core/smx_if.sv
interface smx_in_if;
    logic                       valid;
    logic                       ready;
    logic [smx_pkg::CODE_W-1:0] instr_code;
    logic [smx_pkg::CODE_W-1:0] next_code;

    modport source (output valid, output instr_code, output next_code, input ready);
    modport sink   (input valid, input instr_code, input next_code, output ready);
endinterface

interface smx_out_if;
    logic                                valid;
    logic                                ready;
    logic [smx_pkg::IP_W-1:0]            next_ip;
    logic [smx_pkg::STATUS_W-1:0]        status;
    logic                                print_valid;
    logic signed [smx_pkg::WORD_W-1:0]   print_value;

    modport source (output valid, output next_ip, output status, output print_valid,
                    output print_value, input ready);
    modport sink   (input valid, input next_ip, input status, input print_valid,
                    input print_value, output ready);
endinterface

// File: rtl/core/stack_machine_executor.sv
// A result comes straight from the check when stopped, at the end, at the limit, on a bad op or
// underflow; other instructions read their operands first, and MUL, MOD (one remainder bit per
// cycle), LD, ST and a NEW that takes a slot (clearing its bytes) pass through more states.
// Throughput: one instruction at a time; the block is ready for the next transaction in the cycle after the
// result is registered, and a result that is not taken holds the next one in the commit state.
// Reset: control, stack count, pointer, count and slot table clear at once; memories do not.
module stack_machine_executor
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int SLOT_COUNT  = 10,
    parameter int SLOT_BYTES  = 2048
)
(
    input  logic              clk,
    input  logic              rst_n,
    smx_in_if.sink            instr,
    smx_out_if.source         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [IP_W-1:0]    program_length_reg;
    logic [LIMIT_W-1:0] max_instructions_reg;
    logic [SIZE_W-1:0]  max_buffer_size_reg;
    logic [1:0]         reg_index;
    logic               cfg_write;
    smx_cmd_t           cmd;
    smx_stat_t          stat;
    logic [WORD_W-1:0]  print_value;

    assign pready    = 1'b1;
    assign reg_index = paddr[3:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            program_length_reg   <= '0;
            max_instructions_reg <= MAX_INSTR_RESET;
            max_buffer_size_reg  <= MAX_BUF_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_index)
                REG_PROGRAM_LENGTH:   program_length_reg   <= pwdata[IP_W-1:0];
                REG_MAX_INSTRUCTIONS: max_instructions_reg <= pwdata[LIMIT_W-1:0];
                REG_MAX_BUFFER_SIZE:  max_buffer_size_reg  <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_PROGRAM_LENGTH:   prdata = APB_DW'(program_length_reg);
            REG_MAX_INSTRUCTIONS: prdata = APB_DW'(max_instructions_reg);
            REG_MAX_BUFFER_SIZE:  prdata = APB_DW'(max_buffer_size_reg);
            default:              prdata = '0;
        endcase
    end

    smx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (instr.valid),
        .in_ready (instr.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    smx_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .SLOT_COUNT  (SLOT_COUNT),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .instr_code       (instr.instr_code),
        .next_code        (instr.next_code),
        .program_length   (program_length_reg),
        .max_instructions (max_instructions_reg),
        .max_buffer_size  (max_buffer_size_reg),
        .out_ready        (result.ready),
        .out_valid        (result.valid),
        .out_next_ip      (result.next_ip),
        .out_status       (result.status),
        .out_print_valid  (result.print_valid),
        .out_print_value  (print_value)
    );

    assign result.print_value = $signed(print_value);

endmodule

// File: rtl/core/smx_mod.sv
module smx_mod
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WORD_W-1:0] dividend,
    input  logic [WORD_W-1:0] divisor,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    localparam int CNT_W = $clog2(WORD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WORD_W-1:0] quo_reg;
    logic [WORD_W-1:0] rem_reg;
    logic [WORD_W-1:0] den_reg;
    logic              neg_reg;
    logic [WORD_W:0]   shifted;
    logic [WORD_W:0]   diff;

    // One restoring step per cycle on the magnitudes; the sign of the dividend is applied last.
    assign shifted = {rem_reg, quo_reg[WORD_W-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(WORD_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend[WORD_W-1] ? (~dividend + WORD_W'(1)) : dividend;
            den_reg <= divisor[WORD_W-1] ? (~divisor + WORD_W'(1)) : divisor;
            rem_reg <= '0;
            neg_reg <= dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[WORD_W-2:0], 1'b0};
            if (!diff[WORD_W])
                rem_reg <= diff[WORD_W-1:0];
            else
                rem_reg <= shifted[WORD_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = neg_reg ? (~rem_reg + WORD_W'(1)) : rem_reg;

endmodule

// File: rtl/core/smx_dp.sv
module smx_dp
    import smx_pkg::*;
#(
    parameter int STACK_DEPTH = 1024,
    parameter int SLOT_COUNT  = 10,
    parameter int SLOT_BYTES  = 2048
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  smx_cmd_t            cmd,
    output smx_stat_t           stat,
    input  logic [CODE_W-1:0]   instr_code,
    input  logic [CODE_W-1:0]   next_code,
    input  logic [IP_W-1:0]     program_length,
    input  logic [LIMIT_W-1:0]  max_instructions,
    input  logic [SIZE_W-1:0]   max_buffer_size,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [IP_W-1:0]     out_next_ip,
    output logic [STATUS_W-1:0] out_status,
    output logic                out_print_valid,
    output logic [WORD_W-1:0]   out_print_value
);

    localparam int SAW         = $clog2(STACK_DEPTH);
    localparam int SCW         = $clog2(STACK_DEPTH + 1);
    localparam int SIW         = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int BYTES_TOTAL = SLOT_COUNT * SLOT_BYTES;
    localparam int BAW         = $clog2(BYTES_TOTAL);

    // Decoded transaction.
    op_t              op_reg;
    logic [DIGIT_W:0] digit_reg;

    // Stack.
    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [SCW-1:0]    cnt_reg;
    logic [SCW-1:0]    cnt_next;
    logic [SCW-1:0]    rd_diff;
    logic [SCW-1:0]    wr_diff;
    logic [WORD_W-1:0] stk_rd_data;
    logic [WORD_W-1:0] stk_wdata;
    logic [WORD_W-1:0] x_reg, y_reg, z_reg;
    logic [WORD_W-1:0] alu_res;

    // Machine state.
    logic [IP_W-1:0]    ip_reg;
    logic [LIMIT_W-1:0] exec_reg;
    logic               stopped_reg;
    status_t            final_status_reg;

    // Result under construction.
    status_t            res_status_reg;
    logic [NIP_W-1:0]   res_nip_reg;
    logic [NIP_W-1:0]   nip_val;
    logic               pvalid_reg;
    logic [WORD_W-1:0]  pval_reg;
    logic [IP_W-1:0]    jump_ip;
    logic               taken;
    status_t            commit_status;
    logic [NIP_W-1:0]   commit_nip;

    // Output register.
    logic               out_valid_reg;
    logic [IP_W-1:0]    out_nip_reg;
    status_t            out_status_reg;
    logic               out_pvalid_reg;
    logic [WORD_W-1:0]  out_pval_reg;

    // Multiply and modulo.
    logic [31:0]        mul_a, mul_b;
    logic [WORD_W-1:0]  prod_reg;
    logic [WORD_W-1:0]  acc_reg;
    logic               mod_done;
    logic [WORD_W-1:0]  mod_result;

    // Slot buffers.
    logic [7:0]         slot_mem [BYTES_TOTAL];
    logic               in_use_reg [SLOT_COUNT];
    logic [SIZE_W-1:0]  size_reg [SLOT_COUNT];
    logic [SIW-1:0]     x_idx;
    logic               x_in_range;
    logic               free_found;
    logic [SIW-1:0]     free_idx;
    logic [BAW-1:0]     slot_addr_reg;
    logic [BAW-1:0]     clr_addr_reg;
    logic [SIZE_W-1:0]  clr_left_reg;
    logic [7:0]         slot_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= decode_op(instr_code);
            digit_reg <= decode_digit(next_code);
        end
    end

    assign rd_diff = cnt_reg - SCW'(cmd.rd_depth);
    assign wr_diff = (cmd.wr_addr == WA_FREE) ? cnt_reg : (cnt_reg - SCW'(2));

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  alu_res = x_reg + y_reg;
            OP_SUB:  alu_res = x_reg - y_reg;
            OP_XOR:  alu_res = x_reg ^ y_reg;
            OP_AND:  alu_res = x_reg & y_reg;
            OP_LT:   alu_res = WORD_W'($signed(x_reg) < $signed(y_reg));
            OP_EQ:   alu_res = WORD_W'(x_reg == y_reg);
            default: alu_res = '0;
        endcase
    end

    always_comb
    begin
        unique case (cmd.res_sel)
            RES_ALU:   stk_wdata = alu_res;
            RES_MUL:   stk_wdata = acc_reg;
            RES_MOD:   stk_wdata = mod_result;
            RES_LOAD:  stk_wdata = {{(WORD_W-8){slot_rd_reg[7]}}, slot_rd_reg};
            RES_DIGIT: stk_wdata = WORD_W'(digit_reg[DIGIT_W-1:0]);
            default:   stk_wdata = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.stk_wr)
            stack_mem[wr_diff[SAW-1:0]] <= stk_wdata;
        stk_rd_data <= stack_mem[rd_diff[SAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_x)
            x_reg <= stk_rd_data;
        if (cmd.cap_y)
            y_reg <= stk_rd_data;
        if (cmd.cap_z)
            z_reg <= stk_rd_data;
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC:  cnt_next = cnt_reg + SCW'(1);
            CNT_DEC1: cnt_next = cnt_reg - SCW'(1);
            CNT_DEC2: cnt_next = cnt_reg - SCW'(2);
            CNT_DEC3: cnt_next = cnt_reg - SCW'(3);
            default:  cnt_next = cnt_reg;
        endcase
    end

    // A jump to a negative target or beyond the program lands on the end.
    assign jump_ip = (x_reg[WORD_W-1] || (|x_reg[WORD_W-2:IP_W]) ||
                      (x_reg[IP_W-1:0] >= program_length)) ? program_length : x_reg[IP_W-1:0];
    assign taken   = (op_reg == OP_BRT) == (y_reg != '0);

    always_comb
    begin
        case (cmd.nip_sel)
            NIP_STEP1: nip_val = {1'b0, ip_reg} + NIP_W'(1);
            NIP_STEP2: nip_val = {1'b0, ip_reg} + NIP_W'(2);
            NIP_JUMP:  nip_val = {1'b0, jump_ip};
            NIP_COND:  nip_val = taken ? {1'b0, jump_ip} : ({1'b0, ip_reg} + NIP_W'(1));
            default:   nip_val = {1'b0, ip_reg};
        endcase
    end

    always_comb
    begin
        commit_status = res_status_reg;
        commit_nip    = res_nip_reg;
        if (res_status_reg != ST_RUN)
            commit_nip = {1'b0, ip_reg};
        else if (res_nip_reg >= {1'b0, program_length})
        begin
            commit_nip    = {1'b0, program_length};
            commit_status = ST_END;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            res_status_reg <= cmd.fin_final ? final_status_reg : cmd.fin_status;
            res_nip_reg    <= nip_val;
            pvalid_reg     <= cmd.print;
            pval_reg       <= cmd.print ? x_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg          <= '0;
            ip_reg           <= '0;
            exec_reg         <= '0;
            stopped_reg      <= 1'b0;
            final_status_reg <= ST_RUN;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cmd.count_instr)
                exec_reg <= exec_reg + LIMIT_W'(1);
            if (cmd.commit)
            begin
                ip_reg <= commit_nip[IP_W-1:0];
                if (commit_status != ST_RUN)
                begin
                    stopped_reg      <= 1'b1;
                    final_status_reg <= commit_status;
                end
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_nip_reg    <= commit_nip[IP_W-1:0];
            out_status_reg <= commit_status;
            out_pvalid_reg <= pvalid_reg;
            out_pval_reg   <= pval_reg;
        end
    end

    // The 64-bit product is built from three 32 by 32 partial products.
    always_comb
    begin
        case (cmd.mul_sel)
            MUL_LH:
            begin
                mul_a = x_reg[31:0];
                mul_b = y_reg[63:32];
            end
            MUL_HL:
            begin
                mul_a = x_reg[63:32];
                mul_b = y_reg[31:0];
            end
            default:
            begin
                mul_a = x_reg[31:0];
                mul_b = y_reg[31:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.acc_load)
            acc_reg <= prod_reg;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
    end

    smx_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.mod_start),
        .dividend (x_reg),
        .divisor  (y_reg),
        .done     (mod_done),
        .result   (mod_result)
    );

    assign x_idx      = x_reg[SIW-1:0];
    assign x_in_range = x_reg < WORD_W'(SLOT_COUNT);

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SIW'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                in_use_reg[i] <= 1'b0;
                size_reg[i]   <= '0;
            end
        end
        else if (cmd.slot_alloc)
        begin
            in_use_reg[free_idx] <= 1'b1;
            size_reg[free_idx]   <= x_reg[SIZE_W-1:0];
        end
        else if (cmd.slot_free)
        begin
            in_use_reg[x_idx] <= 1'b0;
            size_reg[x_idx]   <= '0;
        end
    end

    // Only bytes below the slot size are ever read, so NEW clears just that many.
    always_ff @(posedge clk)
    begin
        if (cmd.slot_addr_ld)
            slot_addr_reg <= (BAW'(x_idx) * BAW'(SLOT_BYTES)) + BAW'(y_reg[SIZE_W-1:0]);
        if (cmd.slot_alloc)
        begin
            clr_addr_reg <= BAW'(free_idx) * BAW'(SLOT_BYTES);
            clr_left_reg <= x_reg[SIZE_W-1:0];
        end
        else if (cmd.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + BAW'(1);
            clr_left_reg <= clr_left_reg - SIZE_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
            slot_mem[clr_addr_reg] <= 8'h00;
        else if (cmd.slot_wr)
            slot_mem[slot_addr_reg] <= z_reg[7:0];
        if (cmd.slot_rd)
            slot_rd_reg <= slot_mem[slot_addr_reg];
    end

    assign stat.op         = op_reg;
    assign stat.stopped    = stopped_reg;
    assign stat.at_end     = ip_reg >= program_length;
    assign stat.limit_hit  = exec_reg >= max_instructions;
    assign stat.under      = cnt_reg < SCW'(op_need(op_reg));
    assign stat.stack_full = cnt_reg >= SCW'(STACK_DEPTH);
    assign stat.digit_ok   = digit_reg[DIGIT_W];
    assign stat.y_zero     = y_reg == '0;
    assign stat.slot_ok    = x_in_range && in_use_reg[x_idx];
    assign stat.offset_ok  = (y_reg[WORD_W-1:SIZE_W] == '0) &&
                             (y_reg[SIZE_W-1:0] < size_reg[x_idx]);
    assign stat.size_ok    = (x_reg[WORD_W-1:SIZE_W] == '0) &&
                             (x_reg[SIZE_W-1:0] <= max_buffer_size) &&
                             (x_reg <= WORD_W'(SLOT_BYTES));
    assign stat.free_found = free_found;
    assign stat.clr_done   = clr_left_reg == '0;
    assign stat.mod_done   = mod_done;
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign out_next_ip     = out_nip_reg;
    assign out_status      = out_status_reg;
    assign out_print_valid = out_pvalid_reg;
    assign out_print_value = out_pval_reg;

endmodule

// File: rtl/core/smx_ctrl.sv
module smx_ctrl
    import smx_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  smx_stat_t stat,
    output smx_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic [1:0]  need;

    assign need = op_need(stat.op);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = S_COMMIT;
                if (stat.stopped)
                begin
                    cmd.finish    = 1'b1;
                    cmd.fin_final = 1'b1;
                end
                else if (stat.at_end)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_END;
                end
                else if (stat.limit_hit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_LIMIT;
                end
                else
                begin
                    cmd.count_instr = 1'b1;
                    if (stat.op == OP_BAD)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_BADOP;
                    end
                    else if (stat.under)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_UNDER;
                    end
                    else if (need != 2'd0)
                    begin
                        cmd.rd_depth = 2'd1;
                        state_next   = S_RD2;
                    end
                    else
                        state_next = S_EXEC;
                end
            end
            S_RD2:
            begin
                cmd.cap_x = 1'b1;
                if (need >= 2'd2)
                begin
                    cmd.rd_depth = 2'd2;
                    state_next   = S_RD3;
                end
                else
                    state_next = S_EXEC;
            end
            S_RD3:
            begin
                cmd.cap_y = 1'b1;
                if (need == 2'd3)
                begin
                    cmd.rd_depth = 2'd3;
                    state_next   = S_RD4;
                end
                else
                    state_next = S_EXEC;
            end
            S_RD4:
            begin
                cmd.cap_z  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_COMMIT;
                unique case (stat.op) inside
                    OP_NOP:
                    begin
                        cmd.finish  = 1'b1;
                        cmd.nip_sel = NIP_STEP1;
                    end
                    OP_ADD, OP_SUB, OP_XOR, OP_AND, OP_LT, OP_EQ:
                    begin
                        cmd.stk_wr  = 1'b1;
                        cmd.wr_addr = WA_TOP2;
                        cmd.res_sel = RES_ALU;
                        cmd.cnt_op  = CNT_DEC1;
                        cmd.finish  = 1'b1;
                        cmd.nip_sel = NIP_STEP1;
                    end
                    OP_MUL:
                    begin
                        cmd.mul_sel = MUL_LL;
                        state_next  = S_MUL1;
                    end
                    OP_MOD:
                    begin
                        if (stat.y_zero)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_MODZERO;
                        end
                        else
                        begin
                            cmd.mod_start = 1'b1;
                            state_next    = S_MODW;
                        end
                    end
                    OP_BR:
                    begin
                        cmd.cnt_op  = CNT_DEC1;
                        cmd.finish  = 1'b1;
                        cmd.nip_sel = NIP_JUMP;
                    end
                    OP_BRT, OP_BRF:
                    begin
                        cmd.cnt_op  = CNT_DEC2;
                        cmd.finish  = 1'b1;
                        cmd.nip_sel = NIP_COND;
                    end
                    OP_PUSH:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.stack_full)
                            cmd.fin_status = ST_OVER;
                        else if (!stat.digit_ok)
                            cmd.fin_status = ST_BADDATA;
                        else
                        begin
                            cmd.stk_wr  = 1'b1;
                            cmd.wr_addr = WA_FREE;
                            cmd.res_sel = RES_DIGIT;
                            cmd.cnt_op  = CNT_INC;
                            cmd.nip_sel = NIP_STEP2;
                        end
                    end
                    OP_POP:
                    begin
                        cmd.cnt_op  = CNT_DEC1;
                        cmd.finish  = 1'b1;
                        cmd.nip_sel = NIP_STEP1;
                    end
                    OP_LD, OP_ST:
                    begin
                        if (!stat.slot_ok)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_SLOT;
                        end
                        else if (!stat.offset_ok)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = ST_OFFSET;
                        end
                        else
                        begin
                            cmd.slot_addr_ld = 1'b1;
                            state_next       = (stat.op == OP_LD) ? S_LD1 : S_ST1;
                        end
                    end
                    OP_NEW:
                    begin
                        cmd.finish = 1'b1;
                        if (!stat.size_ok)
                            cmd.fin_status = ST_SIZE;
                        else
                        begin
                            cmd.cnt_op  = CNT_DEC1;
                            cmd.nip_sel = NIP_STEP1;
                            if (stat.free_found)
                            begin
                                cmd.slot_alloc = 1'b1;
                                state_next     = S_CLR;
                            end
                        end
                    end
                    OP_DEL:
                    begin
                        cmd.finish = 1'b1;
                        if (!stat.slot_ok)
                            cmd.fin_status = ST_SLOT;
                        else
                        begin
                            cmd.slot_free = 1'b1;
                            cmd.cnt_op    = CNT_DEC1;
                            cmd.nip_sel   = NIP_STEP1;
                        end
                    end
                    OP_PN:
                    begin
                        cmd.cnt_op  = CNT_DEC1;
                        cmd.print   = 1'b1;
                        cmd.finish  = 1'b1;
                        cmd.nip_sel = NIP_STEP1;
                    end
                    OP_HLT:
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_HALT;
                    end
                    default:
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_UNSUP;
                    end
                endcase
            end
            S_MUL1:
            begin
                cmd.acc_load = 1'b1;
                cmd.mul_sel  = MUL_LH;
                state_next   = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_sel = MUL_HL;
                state_next  = S_MUL3;
            end
            S_MUL3:
            begin
                cmd.acc_add = 1'b1;
                state_next  = S_MULW;
            end
            S_MULW:
            begin
                cmd.stk_wr  = 1'b1;
                cmd.wr_addr = WA_TOP2;
                cmd.res_sel = RES_MUL;
                cmd.cnt_op  = CNT_DEC1;
                cmd.finish  = 1'b1;
                cmd.nip_sel = NIP_STEP1;
                state_next  = S_COMMIT;
            end
            S_MODW:
            begin
                if (stat.mod_done)
                begin
                    cmd.stk_wr  = 1'b1;
                    cmd.wr_addr = WA_TOP2;
                    cmd.res_sel = RES_MOD;
                    cmd.cnt_op  = CNT_DEC1;
                    cmd.finish  = 1'b1;
                    cmd.nip_sel = NIP_STEP1;
                    state_next  = S_COMMIT;
                end
            end
            S_LD1:
            begin
                cmd.slot_rd = 1'b1;
                state_next  = S_LD2;
            end
            S_LD2:
            begin
                cmd.stk_wr  = 1'b1;
                cmd.wr_addr = WA_TOP2;
                cmd.res_sel = RES_LOAD;
                cmd.cnt_op  = CNT_DEC1;
                cmd.finish  = 1'b1;
                cmd.nip_sel = NIP_STEP1;
                state_next  = S_COMMIT;
            end
            S_ST1:
            begin
                cmd.slot_wr = 1'b1;
                cmd.cnt_op  = CNT_DEC3;
                cmd.finish  = 1'b1;
                cmd.nip_sel = NIP_STEP1;
                state_next  = S_COMMIT;
            end
            S_CLR:
            begin
                if (stat.clr_done)
                    state_next = S_COMMIT;
                else
                    cmd.clr_step = 1'b1;
            end
            S_COMMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// File: dv/stack_machine_executor_tb.sv
module stack_machine_executor_tb;
    import smx_pkg::*;

    localparam int  DEPTH       = 1024;
    localparam int  SLOTS       = 10;
    localparam int  SLOT_LEN    = 2048;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  CODE_MAX    = 1114111;
    localparam logic [CODE_W-1:0] DIGIT_CP [11] = '{
        21'h1F600, 21'h1F601, 21'h1F602, 21'h1F923, 21'h1F61C, 21'h1F604,
        21'h1F605, 21'h1F606, 21'h1F609, 21'h1F60A, 21'h1F60D
    };

    typedef struct {
        logic [IP_W-1:0]   nip;
        status_t           st;
        logic              pv;
        logic [WORD_W-1:0] pval;
    } outcome_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    smx_in_if  instr ();
    smx_out_if result ();

    stack_machine_executor dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .instr   (instr.sink),
        .result  (result.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Machine state as the block should hold it.
    logic [WORD_W-1:0] stk [DEPTH];
    int                depth;
    int                cur_ip;
    longint            executed;
    bit                halted;
    status_t           last_st;
    bit                slot_used [SLOTS];
    int                slot_len [SLOTS];
    logic [7:0]        slot_mem [SLOTS][SLOT_LEN];
    longint            prog_len;
    longint            instr_limit;
    longint            buf_limit;

    outcome_t expected_results [$];
    int       errors;
    int       cycles;
    int       snd_pct;
    int       rcv_pct;
    int       hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver side: random stalls, or a long hold-off when one is requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            result.ready <= ($urandom_range(0, 99) >= rcv_pct);
        end
    end

    always @(posedge clk)
    begin
        outcome_t e;
        if (result.valid && result.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result next_ip=%0d status=%0d", $time,
                         result.next_ip, result.status);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result.next_ip !== e.nip)
                begin
                    $display("%0t: next_ip expected %0d actual %0d", $time, e.nip,
                             result.next_ip);
                    errors++;
                end
                if (result.status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st,
                             result.status);
                    errors++;
                end
                if (result.print_valid !== e.pv)
                begin
                    $display("%0t: print_valid expected %0d actual %0d", $time, e.pv,
                             result.print_valid);
                    errors++;
                end
                if (result.print_value !== e.pval)
                begin
                    $display("%0t: print_value expected %h actual %h", $time, e.pval,
                             result.print_value);
                    errors++;
                end
            end
        end
    end

    function automatic logic [CODE_W-1:0] code_of(input op_t op);
        case (op)
            OP_NOP:  return 21'h1F233;
            OP_ADD:  return 21'h02795;
            OP_SUB:  return 21'h02796;
            OP_MUL:  return 21'h0274C;
            OP_MOD:  return 21'h02753;
            OP_XOR:  return 21'h0274E;
            OP_AND:  return 21'h1F46B;
            OP_LT:   return 21'h1F480;
            OP_EQ:   return 21'h1F4AF;
            OP_BR:   return 21'h1F680;
            OP_BRT:  return 21'h1F236;
            OP_BRF:  return 21'h1F21A;
            OP_PUSH: return 21'h023EC;
            OP_POP:  return 21'h1F51D;
            OP_LD:   return 21'h1F4E4;
            OP_ST:   return 21'h1F4E5;
            OP_NEW:  return 21'h1F195;
            OP_DEL:  return 21'h1F193;
            OP_RB:   return 21'h1F4C4;
            OP_WB:   return 21'h1F4DD;
            OP_PSTK: return 21'h1F521;
            OP_PN:   return 21'h1F522;
            OP_HLT:  return 21'h1F6D1;
            default: return 21'h0;
        endcase
    endfunction

    function automatic op_t op_of(input logic [CODE_W-1:0] code);
        op_t op;
        op = OP_NOP;
        for (int i = 0; i < 23; i++)
        begin
            if (code_of(op) == code)
                return op;
            op = op.next();
        end
        return OP_BAD;
    endfunction

    function automatic int digit_of(input logic [CODE_W-1:0] code);
        for (int i = 0; i < 11; i++)
            if (DIGIT_CP[i] == code)
                return i;
        return -1;
    endfunction

    function automatic int operands_of(input op_t op);
        case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_XOR, OP_AND, OP_LT, OP_EQ,
            OP_BRT, OP_BRF, OP_LD: return 2;
            OP_BR, OP_POP, OP_NEW, OP_DEL, OP_PN: return 1;
            OP_ST: return 3;
            default: return 0;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] abs64(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? -v : v;
    endfunction

    function automatic int jump_to(input logic [WORD_W-1:0] v);
        if (v[WORD_W-1] || v >= prog_len)
            return int'(prog_len);
        return int'(v);
    endfunction

    function automatic bit slot_valid(input logic [WORD_W-1:0] v);
        return v < SLOTS && slot_used[v];
    endfunction

    task automatic execute_model(input logic [CODE_W-1:0] code, input logic [CODE_W-1:0] nxt);
        outcome_t o;
        op_t op;
        status_t st;
        int nip;
        int d;
        logic [WORD_W-1:0] x, y, z, r;
        st = ST_RUN;
        nip = cur_ip;
        o.pv = 1'b0;
        o.pval = '0;
        x = '0;
        y = '0;
        z = '0;
        r = '0;
        if (halted)
            st = last_st;
        else if (cur_ip >= prog_len)
            st = ST_END;
        else if (executed + 1 > instr_limit)
            st = ST_LIMIT;
        else
        begin
            executed++;
            op = op_of(code);
            if (op == OP_BAD)
                st = ST_BADOP;
            else if (depth < operands_of(op))
                st = ST_UNDER;
            else
            begin
                if (operands_of(op) >= 1) x = stk[depth - 1];
                if (operands_of(op) >= 2) y = stk[depth - 2];
                if (operands_of(op) >= 3) z = stk[depth - 3];
                nip = cur_ip + 1;
                case (op)
                    OP_NOP: ;
                    OP_ADD, OP_SUB, OP_MUL, OP_MOD, OP_XOR, OP_AND, OP_LT, OP_EQ:
                    begin
                        case (op)
                            OP_ADD: r = x + y;
                            OP_SUB: r = x - y;
                            OP_MUL: r = x * y;
                            OP_XOR: r = x ^ y;
                            OP_AND: r = x & y;
                            OP_LT:  r = ($signed(x) < $signed(y)) ? 64'd1 : 64'd0;
                            OP_EQ:  r = (x == y) ? 64'd1 : 64'd0;
                            default:
                            begin
                                r = (y == 0) ? '0 : abs64(x) % abs64(y);
                                if (x[WORD_W-1])
                                    r = -r;
                            end
                        endcase
                        if (op == OP_MOD && y == 0)
                            st = ST_MODZERO;
                        else
                        begin
                            depth--;
                            stk[depth - 1] = r;
                        end
                    end
                    OP_BR:
                    begin
                        depth--;
                        nip = jump_to(x);
                    end
                    OP_BRT, OP_BRF:
                    begin
                        depth -= 2;
                        if ((op == OP_BRT) == (y != 0))
                            nip = jump_to(x);
                    end
                    OP_PUSH:
                    begin
                        d = digit_of(nxt);
                        if (depth >= DEPTH)
                            st = ST_OVER;
                        else if (d < 0)
                            st = ST_BADDATA;
                        else
                        begin
                            stk[depth] = d;
                            depth++;
                            nip = cur_ip + 2;
                        end
                    end
                    OP_POP: depth--;
                    OP_LD, OP_ST:
                    begin
                        if (!slot_valid(x))
                            st = ST_SLOT;
                        else if (y >= slot_len[x])
                            st = ST_OFFSET;
                        else if (op == OP_LD)
                        begin
                            depth--;
                            stk[depth - 1] = {{56{slot_mem[x][y][7]}}, slot_mem[x][y]};
                        end
                        else
                        begin
                            slot_mem[x][y] = z[7:0];
                            depth -= 3;
                        end
                    end
                    OP_NEW:
                    begin
                        if (x > buf_limit || x > SLOT_LEN)
                            st = ST_SIZE;
                        else
                        begin
                            depth--;
                            // A full slot table swallows the request quietly.
                            for (int i = 0; i < SLOTS; i++)
                            begin
                                if (!slot_used[i])
                                begin
                                    slot_used[i] = 1'b1;
                                    slot_len[i] = int'(x);
                                    for (int j = 0; j < SLOT_LEN; j++)
                                        slot_mem[i][j] = 8'h00;
                                    break;
                                end
                            end
                        end
                    end
                    OP_DEL:
                    begin
                        if (!slot_valid(x))
                            st = ST_SLOT;
                        else
                        begin
                            slot_used[x] = 1'b0;
                            slot_len[x] = 0;
                            depth--;
                        end
                    end
                    OP_PN:
                    begin
                        depth--;
                        o.pv = 1'b1;
                        o.pval = x;
                    end
                    OP_HLT: st = ST_HALT;
                    default: st = ST_UNSUP;
                endcase
                if (st != ST_RUN)
                    nip = cur_ip;
                else if (nip >= prog_len)
                begin
                    nip = int'(prog_len);
                    st = ST_END;
                end
            end
            cur_ip = nip;
        end
        if (st != ST_RUN)
        begin
            halted = 1'b1;
            last_st = st;
        end
        if (!o.pv)
            o.pval = '0;
        o.nip = cur_ip[IP_W-1:0];
        o.st = st;
        expected_results.push_back(o);
    endtask

    task automatic send_item(input logic [CODE_W-1:0] code, input logic [CODE_W-1:0] nxt);
        if ($urandom_range(0, 99) < snd_pct)
        begin
            instr.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        instr.valid      <= 1'b1;
        instr.instr_code <= code;
        instr.next_code  <= nxt;
        @(posedge clk);
        while (!instr.ready)
            @(posedge clk);
        execute_model(code, nxt);
    endtask

    task automatic push_digit(input int d);
        send_item(code_of(OP_PUSH), DIGIT_CP[d]);
    endtask

    task automatic run_op(input op_t op);
        send_item(code_of(op), CODE_W'($urandom_range(0, CODE_MAX)));
    endtask

    task automatic wait_drained();
        instr.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (5) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PROGRAM_LENGTH:   prog_len = val & 32'h1FFFF;
            REG_MAX_INSTRUCTIONS: instr_limit = val;
            default:              buf_limit = val & 32'h7FF;
        endcase
    endtask

    task automatic configure(input longint plen, input longint lim, input longint mbs);
        wait_drained();
        write_reg(REG_PROGRAM_LENGTH, APB_DW'(plen));
        write_reg(REG_MAX_INSTRUCTIONS, APB_DW'(lim));
        write_reg(REG_MAX_BUFFER_SIZE, APB_DW'(mbs));
    endtask

    // Jump back to the start so that the pointer never runs into the end.
    task automatic rewind();
        push_digit(0);
        run_op(OP_BR);
    endtask

    function automatic int pick_slot(input bit need_bytes);
        int cand [$];
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && (!need_bytes || slot_len[i] > 0))
                cand.push_back(i);
        if (cand.size() == 0)
            return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic binop(input op_t op, input int a, input int b);
        push_digit(b);
        push_digit(a);
        run_op(op);
    endtask

    task automatic test_directed();
        binop(OP_SUB, 0, 1);
        run_op(OP_PN);
        push_digit(4);
        binop(OP_SUB, 0, 9);
        run_op(OP_MOD);
        run_op(OP_PN);
        binop(OP_MUL, 10, 10);
        binop(OP_ADD, 3, 7);
        binop(OP_XOR, 5, 10);
        binop(OP_AND, 9, 3);
        binop(OP_LT, 2, 8);
        binop(OP_EQ, 6, 6);
        run_op(OP_NOP);
        run_op(OP_POP);
    endtask

    task automatic random_slot_op();
        int s;
        int kind;
        kind = $urandom_range(0, 3);
        s = pick_slot(kind < 2);
        if (kind == 3 || s < 0)
        begin
            push_digit(buf_limit == 0 ? 0 : $urandom_range(0, 10));
            run_op(OP_NEW);
        end
        else if (kind == 2)
        begin
            push_digit(s);
            run_op(OP_DEL);
        end
        else
        begin
            if (kind == 0)
            begin
                // Negative data reaches the sign extension on a later load.
                if ($urandom_range(0, 1))
                    binop(OP_SUB, $urandom_range(0, 10), $urandom_range(0, 10));
                else
                    push_digit($urandom_range(0, 10));
            end
            push_digit($urandom_range(0, slot_len[s] > 11 ? 10 : slot_len[s] - 1));
            push_digit(s);
            run_op(kind == 0 ? OP_ST : OP_LD);
        end
    endtask

    task automatic random_plain_op();
        op_t op;
        int n;
        n = $urandom_range(0, 11);
        case (n)
            0: op = OP_ADD;
            1: op = OP_SUB;
            2: op = OP_MUL;
            3: op = OP_MOD;
            4: op = OP_XOR;
            5: op = OP_AND;
            6: op = OP_LT;
            7: op = OP_EQ;
            8: op = OP_POP;
            9: op = OP_PN;
            10: op = OP_NOP;
            default: op = OP_PUSH;
        endcase
        if (op == OP_PUSH || depth < operands_of(op) ||
            (op == OP_MOD && stk[depth - 2] == 0))
            push_digit($urandom_range(0, 10));
        else
            run_op(op);
    endtask

    task automatic test_random(input int count);
        longint start;
        int kind;
        start = executed;
        while (executed - start < count)
        begin
            kind = $urandom_range(0, 9);
            if (cur_ip > prog_len - 100)
                rewind();
            else if (depth > DEPTH - 20)
                run_op(OP_POP);
            else if (kind < 5)
                random_plain_op();
            else if (kind < 8)
                random_slot_op();
            else if (kind == 8)
            begin
                push_digit($urandom_range(0, 1));
                push_digit($urandom_range(0, 10));
                run_op($urandom_range(0, 1) ? OP_BRT : OP_BRF);
            end
            else
            begin
                push_digit($urandom_range(0, 10));
                run_op(OP_BR);
            end
        end
    endtask

    task automatic test_large_buffer();
        int s;
        s = pick_slot(1'b0);
        if (s >= 0)
        begin
            push_digit(s);
            run_op(OP_DEL);
        end
        binop(OP_MUL, 10, 10);
        push_digit(10);
        run_op(OP_MUL);
        run_op(OP_NEW);
    endtask

    task automatic test_pressure();
        hold_left = 400;
        for (int i = 0; i < 30; i++)
            random_plain_op();
    endtask

    task automatic test_final_fault();
        int s;
        rewind();
        case ($urandom_range(0, 12))
            0: send_item(CODE_W'($urandom_range(1, 21'h1FFFFF) | 21'h100000), '0);
            1:
            begin
                while (depth > 0)
                    run_op(OP_POP);
                run_op(OP_ADD);
            end
            2: run_op(OP_HLT);
            3: run_op($urandom_range(0, 2) == 0 ? OP_RB : ($urandom_range(0, 1) ? OP_WB
                                                                                 : OP_PSTK));
            4: send_item(code_of(OP_PUSH), CODE_W'($urandom_range(0, 21'h1F5FF)));
            5: binop(OP_MOD, 1, 0);
            6:
            begin
                push_digit(10);
                run_op(OP_DEL);
            end
            7:
            begin
                if (pick_slot(1'b0) < 0)
                begin
                    push_digit(1);
                    run_op(OP_NEW);
                end
                s = pick_slot(1'b0);
                binop(OP_SUB, 0, 1);
                push_digit(s);
                run_op(OP_LD);
            end
            8:
            begin
                binop(OP_MUL, 10, 10);
                binop(OP_MUL, 10, 10);
                run_op(OP_MUL);
                run_op(OP_NEW);
            end
            9:
            begin
                configure(prog_len, executed, buf_limit);
                run_op(OP_NOP);
            end
            10:
            begin
                configure(cur_ip + 1, instr_limit, buf_limit);
                run_op(OP_NOP);
            end
            11:
            begin
                while (depth < DEPTH)
                    push_digit($urandom_range(0, 10));
                push_digit(0);
            end
            default:
            begin
                // A negative branch target lands on the end of the program.
                binop(OP_SUB, 0, 1);
                run_op(OP_BR);
            end
        endcase
    endtask

    task automatic test_after_stop();
        for (int i = 0; i < 12; i++)
            send_item(CODE_W'($urandom_range(0, CODE_MAX)), CODE_W'($urandom_range(0, CODE_MAX)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        instr.valid = 1'b0;
        instr.instr_code = '0;
        instr.next_code = '0;
        result.ready = 1'b0;
        errors = 0;
        cycles = 0;
        hold_left = 0;
        snd_pct = 0;
        rcv_pct = 0;
        depth = 0;
        cur_ip = 0;
        executed = 0;
        halted = 1'b0;
        last_st = ST_RUN;
        prog_len = 0;
        instr_limit = MAX_INSTR_RESET;
        buf_limit = MAX_BUF_RESET;
        for (int i = 0; i < SLOTS; i++)
        begin
            slot_used[i] = 1'b0;
            slot_len[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(65536, 32'hFFFFFFFF, 2047);
        test_directed();
        snd_pct = 33;
        rcv_pct = 72;
        test_random(215);
        snd_pct = 72;
        rcv_pct = 33;
        rewind();
        configure(40000, 3000000, 0);
        test_random(215);
        snd_pct = 0;
        rcv_pct = 0;
        configure(40000, 3000000, 2047);
        test_large_buffer();
        test_pressure();
        test_random(190);
        test_final_fault();
        test_after_stop();

        instr.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
rtl/core/smx_pkg.sv
rtl/core/smx_if.sv
rtl/core/smx_mod.sv
rtl/core/smx_dp.sv
rtl/core/smx_ctrl.sv
rtl/core/stack_machine_executor.sv
dv/stack_machine_executor_tb.sv
